### rtl/fsdlf_pkg.sv
// Shared types, constants and the control store for the diode ladder filter.
// Used by the sequencer, the datapath and the top level.
// No dependencies.
package fsdlf_pkg;

  localparam int FRAC_BITS_DEF  = 24;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 5;

  // output saturation limits (magnitudes)
  localparam int OUT_POS_LIM = 32767;
  localparam int OUT_NEG_LIM = 32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FEED_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HP_PREV_COEF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HP_POLE_COEF  = 3'd5;

  localparam logic [PC_W-1:0] STEP_IDLE = 5'd0;

  typedef enum logic [1:0] {
    C_NEXT,      // advance every cycle
    C_WAIT_IN,   // hold until an item is taken
    C_WAIT_MUL,  // hold until the product is ready
    C_WAIT_OUT   // hold until the output register is free, then jump
  } cond_t;

  typedef enum logic [2:0] {
    COEF_B, COEF_K, COEF_G, COEF_HF, COEF_HP, COEF_HA
  } coef_t;

  typedef enum logic [3:0] {
    SRC_S1, SRC_S2, SRC_S3, SRC_S4, SRC_Y, SRC_D, SRC_H,
    SRC_HLIN, SRC_HLOUT, SRC_P, SRC_ACC
  } src_t;

  typedef enum logic [2:0] {
    SC_ZERO, SC_POS, SC_NEG, SC_POS2, SC_NEG2
  } scale_t;

  typedef enum logic [3:0] {
    D_NONE, D_ACC, D_Y, D_D, D_H, D_S1, D_S2, D_S3, D_S4, D_HLIN, D_HLOUT
  } dst_t;

  typedef struct packed {
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             mul_start;
    coef_t            mul_a;
    src_t             mul_b;
    src_t             sa;
    scale_t           ka;
    src_t             sb;
    scale_t           kb;
    src_t             sc;
    scale_t           kc;
    dst_t             dst;
    logic             out_write;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   go;    // current step completes this cycle
    logic   idle;  // waiting for an input item
  } ctrl_t;

  typedef struct packed {
    logic in_take;
    logic mul_done;
    logic out_free;
  } stat_t;

  function automatic uword_t uw_nop();
    uword_t uw;
    uw.cond      = C_NEXT;
    uw.target    = STEP_IDLE;
    uw.mul_start = 1'b0;
    uw.mul_a     = COEF_B;
    uw.mul_b     = SRC_S4;
    uw.sa        = SRC_P;
    uw.ka        = SC_ZERO;
    uw.sb        = SRC_P;
    uw.kb        = SC_ZERO;
    uw.sc        = SRC_P;
    uw.kc        = SC_ZERO;
    uw.dst       = D_NONE;
    uw.out_write = 1'b0;
    return uw;
  endfunction

  function automatic uword_t uw_mul(input coef_t a, input src_t b);
    uword_t uw;
    uw = uw_nop();
    uw.mul_start = 1'b1;
    uw.mul_a     = a;
    uw.mul_b     = b;
    return uw;
  endfunction

  function automatic uword_t uw_alu(input cond_t c, input dst_t d,
                                    input src_t sa, input scale_t ka,
                                    input src_t sb, input scale_t kb,
                                    input src_t sc, input scale_t kc);
    uword_t uw;
    uw = uw_nop();
    uw.cond = c;
    uw.dst  = d;
    uw.sa   = sa;
    uw.ka   = ka;
    uw.sb   = sb;
    uw.kb   = kb;
    uw.sc   = sc;
    uw.kc   = kc;
    return uw;
  endfunction

  // Control store: one sample per pass through the program.
  function automatic uword_t ucode(input logic [PC_W-1:0] step);
    uword_t uw;
    uw = uw_nop();
    unique case (step)
      5'd0: uw.cond = C_WAIT_IN;
      // feedback highpass
      5'd1:  uw = uw_mul(COEF_K, SRC_S4);
      5'd2:  uw = uw_alu(C_WAIT_MUL, D_H, SRC_P, SC_POS, SRC_P, SC_ZERO, SRC_P, SC_ZERO);
      5'd3:  uw = uw_mul(COEF_HF, SRC_H);
      5'd4:  uw = uw_alu(C_WAIT_MUL, D_ACC, SRC_P, SC_POS, SRC_P, SC_ZERO, SRC_P, SC_ZERO);
      5'd5:  uw = uw_mul(COEF_HP, SRC_HLIN);
      5'd6:  uw = uw_alu(C_WAIT_MUL, D_ACC, SRC_ACC, SC_POS, SRC_P, SC_POS, SRC_P, SC_ZERO);
      5'd7:  uw = uw_mul(COEF_HA, SRC_HLOUT);
      5'd8:  uw = uw_alu(C_WAIT_MUL, D_HLOUT, SRC_ACC, SC_POS, SRC_P, SC_POS,
                         SRC_P, SC_ZERO);
      5'd9:  uw = uw_alu(C_NEXT, D_Y, SRC_Y, SC_POS, SRC_HLOUT, SC_NEG, SRC_P, SC_ZERO);
      5'd10: uw = uw_alu(C_NEXT, D_HLIN, SRC_H, SC_POS, SRC_P, SC_ZERO, SRC_P, SC_ZERO);
      // ladder stages
      5'd11: uw = uw_alu(C_NEXT, D_D, SRC_Y, SC_POS, SRC_S1, SC_NEG, SRC_S2, SC_POS);
      5'd12: uw = uw_mul(COEF_B, SRC_D);
      5'd13: uw = uw_alu(C_WAIT_MUL, D_S1, SRC_S1, SC_POS, SRC_P, SC_POS2, SRC_P, SC_ZERO);
      5'd14: uw = uw_alu(C_NEXT, D_D, SRC_S1, SC_POS, SRC_S2, SC_NEG2, SRC_S3, SC_POS);
      5'd15: uw = uw_mul(COEF_B, SRC_D);
      5'd16: uw = uw_alu(C_WAIT_MUL, D_S2, SRC_S2, SC_POS, SRC_P, SC_POS, SRC_P, SC_ZERO);
      5'd17: uw = uw_alu(C_NEXT, D_D, SRC_S2, SC_POS, SRC_S3, SC_NEG2, SRC_S4, SC_POS);
      5'd18: uw = uw_mul(COEF_B, SRC_D);
      5'd19: uw = uw_alu(C_WAIT_MUL, D_S3, SRC_S3, SC_POS, SRC_P, SC_POS, SRC_P, SC_ZERO);
      5'd20: uw = uw_alu(C_NEXT, D_D, SRC_S3, SC_POS, SRC_S4, SC_NEG2, SRC_P, SC_ZERO);
      5'd21: uw = uw_mul(COEF_B, SRC_D);
      5'd22: uw = uw_alu(C_WAIT_MUL, D_S4, SRC_S4, SC_POS, SRC_P, SC_POS, SRC_P, SC_ZERO);
      // output gain and result
      5'd23: uw = uw_mul(COEF_G, SRC_S4);
      5'd24: uw = uw_alu(C_WAIT_MUL, D_NONE, SRC_P, SC_ZERO, SRC_P, SC_ZERO,
                         SRC_P, SC_ZERO);
      5'd25: begin
        uw.cond      = C_WAIT_OUT;
        uw.target    = STEP_IDLE;
        uw.out_write = 1'b1;
      end
      default: begin
        uw.cond   = C_WAIT_OUT;
        uw.target = STEP_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

### rtl/fsdlf_mul.sv
// Shared multi-cycle fixed-point multiplier: four half-width partial products,
// then round half up, shift by the fraction width and saturate.
// Depends on nothing but its parameters.
module fsdlf_mul #(
  parameter int FRAC_BITS  = 24,
  parameter int WORD_WIDTH = 32,
  parameter int OP_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [OP_WIDTH-1:0]   op_a,
  input  logic signed [OP_WIDTH-1:0]   op_b,
  output logic signed [WORD_WIDTH-1:0] prod,
  output logic                         done
);

  localparam int H   = (OP_WIDTH + 1) / 2;
  localparam int PW  = 2 * H;
  localparam int ACW = 4 * H;
  localparam logic [2:0] RND_STEP = 3'd4;
  localparam logic [ACW:0] HALF    = (ACW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [ACW:0] LIM_POS = (ACW + 1)'({(WORD_WIDTH - 1){1'b1}});

  logic [OP_WIDTH-1:0]   a_mag, b_mag;
  logic [PW-1:0]         ua, ub;
  logic                  neg;
  logic                  busy;
  logic [2:0]            cnt;
  logic [ACW-1:0]        acc;
  logic [H-1:0]          pa, pb;
  logic [PW-1:0]         pp;
  logic [ACW-1:0]        pp_sh;
  logic [ACW:0]          rsum, rsh, lim, rmag;
  logic [WORD_WIDTH-1:0] rw;

  assign a_mag = op_a[OP_WIDTH-1] ? (~op_a + 1'b1) : op_a;
  assign b_mag = op_b[OP_WIDTH-1] ? (~op_b + 1'b1) : op_b;

  always_comb begin
    pa = cnt[0] ? ua[PW-1:H] : ua[H-1:0];
    pb = cnt[1] ? ub[PW-1:H] : ub[H-1:0];
    pp = PW'(pa) * PW'(pb);
    unique case (cnt[1:0])
      2'd0:       pp_sh = ACW'(pp);
      2'd1, 2'd2: pp_sh = ACW'(pp) << H;
      default:    pp_sh = ACW'(pp) << (2 * H);
    endcase
  end

  // round half up on the magnitude (half minus one when negative)
  always_comb begin
    rsum = (ACW + 1)'(acc) + (neg ? (HALF - 1'b1) : HALF);
    rsh  = rsum >> FRAC_BITS;
    lim  = LIM_POS + (ACW + 1)'(neg);
    rmag = (rsh > lim) ? lim : rsh;
    rw   = rmag[WORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == RND_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= PW'(a_mag);
      ub  <= PW'(b_mag);
      neg <= op_a[OP_WIDTH-1] ^ op_b[OP_WIDTH-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt == RND_STEP) begin
        prod <= neg ? (~rw + 1'b1) : rw;
      end else begin
        acc <= acc + pp_sh;
      end
    end
  end

endmodule

### rtl/fsdlf_dp.sv
// Datapath: coefficient registers, filter state, three-term saturating adder,
// shared multiplier and the output register. Uses fsdlf_pkg and fsdlf_mul.
module fsdlf_dp #(
  parameter int FRAC_BITS  = fsdlf_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = fsdlf_pkg::WORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fsdlf_pkg::ctrl_t                      ctrl,
  input  logic                                  in_take,
  input  logic signed [fsdlf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  cfg_wen,
  input  logic [fsdlf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsdlf_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [fsdlf_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                  clipped,
  output logic                                  mul_done,
  output logic                                  out_free
);
  import fsdlf_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int OPW = (W > CFG_W) ? W : CFG_W;
  localparam int AW0 = W + 4;
  localparam int AW  = (AW0 > FRAC_BITS + 2) ? AW0 : FRAC_BITS + 2;
  localparam int OW  = W + 16;
  localparam logic signed [AW-1:0] WMAX = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [AW-1:0] WMIN = {{(AW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  logic signed [CFG_W-1:0] stage_gain, feedback_gain, output_gain;
  logic signed [CFG_W-1:0] hp_feed_coef, hp_prev_coef, hp_pole_coef;

  logic signed [W-1:0]  s1, s2, s3, s4, hl_in, hl_out;
  logic signed [W-1:0]  yv, dv, hv, pv;
  logic signed [AW-1:0] acc;

  logic signed [CFG_W-1:0] coef_v;
  logic signed [W-1:0]     mb_v;
  logic                    mul_go;

  src_t                 tsel [3];
  scale_t               tscl [3];
  logic signed [AW-1:0] traw [3];
  logic signed [AW-1:0] tval [3];
  logic signed [AW-1:0] sum, sum_sat, x_wide;
  logic signed [W-1:0]  res_w, x_w;

  logic                 qneg, oclip;
  logic [W-1:0]         qmag;
  logic [OW-1:0]        m_full, m_sh, olim;
  logic [16:0]          m_fin, m_neg;

  function automatic logic signed [AW-1:0] sat_w(input logic signed [AW-1:0] v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_gain    <= '0;
      feedback_gain <= '0;
      output_gain   <= CFG_W'(1) << FRAC_BITS;
      hp_feed_coef  <= '0;
      hp_prev_coef  <= '0;
      hp_pole_coef  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_STAGE_GAIN:    stage_gain    <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        REG_OUTPUT_GAIN:   output_gain   <= cfg_data;
        REG_HP_FEED_COEF:  hp_feed_coef  <= cfg_data;
        REG_HP_PREV_COEF:  hp_prev_coef  <= cfg_data;
        REG_HP_POLE_COEF:  hp_pole_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier operands
  always_comb begin
    unique case (ctrl.uw.mul_a)
      COEF_B:  coef_v = stage_gain;
      COEF_K:  coef_v = feedback_gain;
      COEF_G:  coef_v = output_gain;
      COEF_HF: coef_v = hp_feed_coef;
      COEF_HP: coef_v = hp_prev_coef;
      COEF_HA: coef_v = hp_pole_coef;
      default: coef_v = '0;
    endcase
    unique case (ctrl.uw.mul_b)
      SRC_S4:    mb_v = s4;
      SRC_H:     mb_v = hv;
      SRC_HLIN:  mb_v = hl_in;
      SRC_HLOUT: mb_v = hl_out;
      SRC_D:     mb_v = dv;
      default:   mb_v = '0;
    endcase
  end

  assign mul_go = ctrl.go && ctrl.uw.mul_start;

  fsdlf_mul #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (W),
    .OP_WIDTH   (OPW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .op_a  (OPW'(coef_v)),
    .op_b  (OPW'(mb_v)),
    .prod  (pv),
    .done  (mul_done)
  );

  // three-term adder, each term scaled by 0, +-1 or +-2
  always_comb begin
    tsel[0] = ctrl.uw.sa;
    tsel[1] = ctrl.uw.sb;
    tsel[2] = ctrl.uw.sc;
    tscl[0] = ctrl.uw.ka;
    tscl[1] = ctrl.uw.kb;
    tscl[2] = ctrl.uw.kc;
    for (int i = 0; i < 3; i++) begin
      unique case (tsel[i])
        SRC_S1:    traw[i] = AW'(s1);
        SRC_S2:    traw[i] = AW'(s2);
        SRC_S3:    traw[i] = AW'(s3);
        SRC_S4:    traw[i] = AW'(s4);
        SRC_Y:     traw[i] = AW'(yv);
        SRC_D:     traw[i] = AW'(dv);
        SRC_H:     traw[i] = AW'(hv);
        SRC_HLIN:  traw[i] = AW'(hl_in);
        SRC_HLOUT: traw[i] = AW'(hl_out);
        SRC_P:     traw[i] = AW'(pv);
        SRC_ACC:   traw[i] = acc;
        default:   traw[i] = '0;
      endcase
      unique case (tscl[i])
        SC_POS:  tval[i] = traw[i];
        SC_NEG:  tval[i] = -traw[i];
        SC_POS2: tval[i] = traw[i] <<< 1;
        SC_NEG2: tval[i] = -(traw[i] <<< 1);
        default: tval[i] = '0;
      endcase
    end
    sum     = tval[0] + tval[1] + tval[2];
    sum_sat = sat_w(sum);
    res_w   = sum_sat[W-1:0];
  end

  // input scaling to the word format
  always_comb begin
    x_wide = sat_w(AW'(sample_in) <<< (FRAC_BITS - 15));
    x_w    = x_wide[W-1:0];
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1     <= '0;
      s2     <= '0;
      s3     <= '0;
      s4     <= '0;
      hl_in  <= '0;
      hl_out <= '0;
    end else if (ctrl.go) begin
      unique case (ctrl.uw.dst)
        D_S1:    s1     <= res_w;
        D_S2:    s2     <= res_w;
        D_S3:    s3     <= res_w;
        D_S4:    s4     <= res_w;
        D_HLIN:  hl_in  <= res_w;
        D_HLOUT: hl_out <= res_w;
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      yv <= x_w;
    end else if (ctrl.go) begin
      unique case (ctrl.uw.dst)
        D_Y:     yv  <= res_w;
        D_D:     dv  <= res_w;
        D_H:     hv  <= res_w;
        D_ACC:   acc <= sum;
        default: ;
      endcase
    end
  end

  // output scaling: |q| * 65534 >> FRAC_BITS, then 16-bit saturation
  always_comb begin
    qneg   = pv[W-1];
    qmag   = qneg ? (~pv + 1'b1) : pv;
    m_full = {qmag, 16'd0} - {15'd0, qmag, 1'b0};
    m_sh   = m_full >> FRAC_BITS;
    olim   = qneg ? OW'(OUT_NEG_LIM) : OW'(OUT_POS_LIM);
    oclip  = m_sh > olim;
    m_fin  = oclip ? olim[16:0] : m_sh[16:0];
    m_neg  = 17'd0 - m_fin;
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.go && ctrl.uw.out_write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.uw.out_write) begin
      sample_out <= qneg ? m_neg[15:0] : m_fin[15:0];
      clipped    <= oclip;
    end
  end

endmodule

### rtl/fsdlf_seq.sv
// Microcode sequencer: step counter over the control store in fsdlf_pkg,
// with wait conditions and the jump back to the idle step.
module fsdlf_seq (
  input  logic             clk,
  input  logic             rst,
  input  fsdlf_pkg::stat_t stat,
  output fsdlf_pkg::ctrl_t ctrl
);
  import fsdlf_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  uword_t          uw;
  logic            go;

  always_comb begin
    uw = ucode(pc);
    unique case (uw.cond)
      C_NEXT:     go = 1'b1;
      C_WAIT_IN:  go = stat.in_take;
      C_WAIT_MUL: go = stat.mul_done;
      C_WAIT_OUT: go = stat.out_free;
      default:    go = 1'b0;
    endcase
    pc_next = pc;
    if (go) begin
      pc_next = (uw.cond == C_WAIT_OUT) ? uw.target : pc + 1'b1;
    end
    ctrl.uw   = uw;
    ctrl.go   = go;
    ctrl.idle = (uw.cond == C_WAIT_IN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/four_stage_diode_ladder_filter.sv
// Top level of the four-pole diode ladder filter.
// Uses fsdlf_pkg, fsdlf_seq and fsdlf_dp.
//
// One signed 16-bit sample in, one filtered 16-bit sample out with a clip
// flag. Per item the block highpasses the resonance feedback (feedback_gain
// times the last stage), subtracts it from the input and runs four coupled
// leaky-integrator stages; the result is 2 * output_gain * stage four, scaled
// to 16 bits and saturated. All arithmetic is signed fixed point, FRAC_BITS
// fraction bits in WORD_WIDTH-bit words; products and word results are
// saturated, only the wider accumulator keeps an unsaturated sum. Control is
// a 26-step microprogram; all nine products share one multiplier that builds
// each product from four half-width partial products and a rounding step.
// An item is accepted at the idle step; the program returns there only after
// loading the result into the output register, so one item is processed at a
// time. A finished result waits in the output register while the next item
// is accepted and processed. Coefficients are written through cfg_wen /
// cfg_index / cfg_data; the user must write them only while the block is
// idle, which the block does not enforce. Indexes six and seven are ignored.
module four_stage_diode_ladder_filter #(
  parameter int FRAC_BITS  = fsdlf_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = fsdlf_pkg::WORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input samples
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fsdlf_pkg::SAMPLE_W-1:0] sample_in,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fsdlf_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                  clipped,
  // coefficient writes
  input  logic                                  cfg_wen,
  input  logic [fsdlf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsdlf_pkg::CFG_W-1:0]           cfg_data
);
  import fsdlf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_take;
  logic  mul_done;
  logic  out_free;

  // an item is taken only while the program sits at its idle step
  assign in_stall = !ctrl.idle;
  assign in_take  = in_valid && ctrl.idle;

  always_comb begin
    stat.in_take  = in_take;
    stat.mul_done = mul_done;
    stat.out_free = out_free;
  end

  fsdlf_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  fsdlf_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_take    (in_take),
    .sample_in  (sample_in),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .clipped    (clipped),
    .mul_done   (mul_done),
    .out_free   (out_free)
  );

endmodule

### rtl/fsdlf_checker.sv
// Port-level checks for the diode ladder filter, bound to the top level.
// Depends only on the top level's port names.
module fsdlf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] sample_out,
  input logic               clipped
);

  logic [1:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input taken while an item is in progress");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample_out == 16'h7fff || sample_out == 16'h8000))
    else $error("clip flag without a saturated sample");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two items in flight");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result with no item outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result changed");

endmodule

bind four_stage_diode_ladder_filter fsdlf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .clipped    (clipped)
);
